>>> src/tfr_pkg.sv
package tfr_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'hD8;
	localparam logic [7:0] TAIL_BYTE    = 8'hEE;
	localparam logic [7:0] TAG_LEFT     = 8'hB0;
	localparam logic [7:0] TAG_RIGHT    = 8'hB1;
	localparam logic [7:0] TAG_POSITION = 8'hB2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TAIL_ERR   = 2'd1;
	localparam logic [1:0] ST_HEADER_ERR = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		KIND_SKIP,
		KIND_HDR_ERR,
		KIND_TAG_L,
		KIND_L_HI,
		KIND_L_LO,
		KIND_TAG_R,
		KIND_R_HI,
		KIND_R_LO,
		KIND_TAG_P,
		KIND_P_HI,
		KIND_P_LO,
		KIND_TAIL
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [7:0]  data;
	} entry_t;

endpackage

>>> src/tfr_front.sv
module tfr_front
	import tfr_pkg::*;
#(
	parameter int FRAME_LENGTH = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	localparam int PosW = $clog2(FRAME_LENGTH);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_next;
	byte_kind_t      kind;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		kind     = KIND_SKIP;
		pos_next = pos_q + PosW'(1);
		if (pos_q == PosW'(FRAME_LENGTH - 1)) begin
			kind     = KIND_TAIL;
			pos_next = '0;
		end else begin
			unique case (pos_q)
				PosW'(0): begin
					if (rx_byte != HEADER_BYTE) begin
						kind     = KIND_HDR_ERR;
						pos_next = '0;
					end
				end
				PosW'(1): kind = KIND_TAG_L;
				PosW'(2): kind = KIND_L_HI;
				PosW'(3): kind = KIND_L_LO;
				PosW'(4): kind = KIND_TAG_R;
				PosW'(5): kind = KIND_R_HI;
				PosW'(6): kind = KIND_R_LO;
				PosW'(7): kind = KIND_TAG_P;
				PosW'(8): kind = KIND_P_HI;
				PosW'(9): kind = KIND_P_LO;
				default:  kind = KIND_SKIP;
			endcase
		end
	end

	assign q_entry.kind = kind;
	assign q_entry.data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= pos_next;
		end
	end

endmodule

>>> src/tfr_queue.sv
module tfr_queue
	import tfr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	output logic   pop_valid,
	output entry_t pop_entry,
	input  logic   pop
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full      = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

>>> src/tfr_back.sv
module tfr_back
	import tfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  entry_t             q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         frame_status,
	output logic signed [15:0] left_count,
	output logic signed [15:0] right_count,
	output logic signed [15:0] steer_position,
	output logic               left_fresh,
	output logic               right_fresh,
	output logic               position_fresh
);

	logic [7:0]  tag_l_q, tag_r_q, tag_p_q;
	logic [7:0]  l_hi_q, r_hi_q, p_hi_q;
	logic [7:0]  l_lo_q, r_lo_q, p_lo_q;
	logic [15:0] held_left_q, held_right_q, held_position_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        left_fresh_q, right_fresh_q, position_fresh_q;

	logic        emits;
	logic        out_free;
	logic        tail_ok;
	logic        lf, rf, pf;
	logic [15:0] left_next, right_next, position_next;

	assign emits    = (q_entry.kind == KIND_TAIL) || (q_entry.kind == KIND_HDR_ERR);
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = q_valid && (!emits || out_free);

	assign tail_ok = q_entry.data == TAIL_BYTE;
	assign lf      = tail_ok && (tag_l_q == TAG_LEFT);
	assign rf      = tail_ok && (tag_r_q == TAG_RIGHT);
	assign pf      = tail_ok && (tag_p_q == TAG_POSITION);

	assign left_next     = lf ? {l_hi_q, l_lo_q} : held_left_q;
	assign right_next    = rf ? {r_hi_q, r_lo_q} : held_right_q;
	assign position_next = pf ? {p_hi_q, p_lo_q} : held_position_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			case (q_entry.kind)
				KIND_TAG_L: tag_l_q <= q_entry.data;
				KIND_L_HI:  l_hi_q  <= q_entry.data;
				KIND_L_LO:  l_lo_q  <= q_entry.data;
				KIND_TAG_R: tag_r_q <= q_entry.data;
				KIND_R_HI:  r_hi_q  <= q_entry.data;
				KIND_R_LO:  r_lo_q  <= q_entry.data;
				KIND_TAG_P: tag_p_q <= q_entry.data;
				KIND_P_HI:  p_hi_q  <= q_entry.data;
				KIND_P_LO:  p_lo_q  <= q_entry.data;
				default: ;
			endcase
		end
		if (q_pop && emits) begin
			if (q_entry.kind == KIND_TAIL) begin
				status_q         <= tail_ok ? ST_OK : ST_TAIL_ERR;
				left_fresh_q     <= lf;
				right_fresh_q    <= rf;
				position_fresh_q <= pf;
			end else begin
				status_q         <= ST_HEADER_ERR;
				left_fresh_q     <= 1'b0;
				right_fresh_q    <= 1'b0;
				position_fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			held_left_q     <= '0;
			held_right_q    <= '0;
			held_position_q <= '0;
		end else begin
			if (q_pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop && (q_entry.kind == KIND_TAIL)) begin
				held_left_q     <= left_next;
				held_right_q    <= right_next;
				held_position_q <= position_next;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_status   = status_q;
	assign left_count     = $signed(held_left_q);
	assign right_count    = $signed(held_right_q);
	assign steer_position = $signed(held_position_q);
	assign left_fresh     = left_fresh_q;
	assign right_fresh    = right_fresh_q;
	assign position_fresh = position_fresh_q;

endmodule

>>> src/tagged_frame_receiver.sv
// The byte that completes or rejects a frame passes through the queue to the frame
// decode, which registers the result. Throughput: one byte per cycle while in_stall
// is low; a four-entry queue between byte classification and frame decode lets the
// input flow while a result waits on out_stall, until the queue fills. Results hold
// the latest decoded values; the fresh flags mark this frame's updates. Reset (arst_n
// low, asynchronous): frame position, queue, held values and output valid clear to zero.
module tagged_frame_receiver
	import tfr_pkg::*;
#(
	parameter int FRAME_LENGTH = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         frame_status,
	output logic signed [15:0] left_count,
	output logic signed [15:0] right_count,
	output logic signed [15:0] steer_position,
	output logic               left_fresh,
	output logic               right_fresh,
	output logic               position_fresh
);

	logic   q_full;
	logic   q_push;
	entry_t push_entry;
	logic   q_valid;
	entry_t pop_entry;
	logic   q_pop;

	tfr_front #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	tfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_entry  (pop_entry),
		.pop        (q_pop)
	);

	tfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_entry        (pop_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.left_count     (left_count),
		.right_count    (right_count),
		.steer_position (steer_position),
		.left_fresh     (left_fresh),
		.right_fresh    (right_fresh),
		.position_fresh (position_fresh)
	);

endmodule

>>> src/tfr_checker.sv
module tfr_checker
	import tfr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         frame_status,
	input logic signed [15:0] left_count,
	input logic signed [15:0] right_count,
	input logic signed [15:0] steer_position,
	input logic               left_fresh,
	input logic               right_fresh,
	input logic               position_fresh
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(frame_status) && $stable(left_count)
			&& $stable(right_count) && $stable(steer_position))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status == ST_OK || frame_status == ST_TAIL_ERR
			|| frame_status == ST_HEADER_ERR)
		else $error("bad frame status");

	a_fresh_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != ST_OK |-> !left_fresh && !right_fresh && !position_fresh)
		else $error("fresh flag on failed frame");

	a_held_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid && frame_status != ST_OK
			|-> left_count == $past(left_count) && right_count == $past(right_count)
			&& steer_position == $past(steer_position))
		else $error("held value changed on failed frame");

endmodule

bind tagged_frame_receiver tfr_checker u_tfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.frame_status   (frame_status),
	.left_count     (left_count),
	.right_count    (right_count),
	.steer_position (steer_position),
	.left_fresh     (left_fresh),
	.right_fresh    (right_fresh),
	.position_fresh (position_fresh)
);

>>> test/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker
	import tfr_pkg::*;
#(
	parameter int FRAME_LENGTH = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  frame_status,
	input  logic [15:0] left_count,
	input  logic [15:0] right_count,
	input  logic [15:0] steer_position,
	input  logic        left_fresh,
	input  logic        right_fresh,
	input  logic        position_fresh,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] steer;
		logic        left_new;
		logic        right_new;
		logic        steer_new;
	} frame_report_t;

	frame_report_t reports_due[$];
	int            next_index;
	logic [7:0]    frame_bytes [FRAME_LENGTH];
	logic [15:0]   held_left;
	logic [15:0]   held_right;
	logic [15:0]   held_steer;

	task automatic take_byte(input logic [7:0] b);
		frame_report_t r;
		int idx;
		idx = (next_index >= FRAME_LENGTH) ? 0 : next_index;
		frame_bytes[idx] = b;
		idx++;
		r = '0;
		if (idx == 1 && b != HEADER_BYTE) begin
			next_index = 0;
			r.status = ST_HEADER_ERR;
		end else if (idx == FRAME_LENGTH) begin
			next_index = 0;
			if (frame_bytes[FRAME_LENGTH-1] != TAIL_BYTE) begin
				r.status = ST_TAIL_ERR;
			end else begin
				r.status = ST_OK;
				r.left_new = (frame_bytes[1] == TAG_LEFT);
				r.right_new = (frame_bytes[4] == TAG_RIGHT);
				r.steer_new = (frame_bytes[7] == TAG_POSITION);
				if (r.left_new)
					held_left = {frame_bytes[2], frame_bytes[3]};
				if (r.right_new)
					held_right = {frame_bytes[5], frame_bytes[6]};
				if (r.steer_new)
					held_steer = {frame_bytes[8], frame_bytes[9]};
			end
		end else begin
			next_index = idx;
			return;
		end
		r.left = held_left;
		r.right = held_right;
		r.steer = held_steer;
		reports_due.push_back(r);
	endtask

	task automatic report_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_report_t exp_r;
		if (!arst_n) begin
			reports_due.delete();
			next_index = 0;
			held_left = '0;
			held_right = '0;
			held_steer = '0;
			failures = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h %h %h %b%b%b",
						$time, frame_status, left_count, right_count, steer_position,
						left_fresh, right_fresh, position_fresh);
					failures++;
				end else begin
					exp_r = reports_due.pop_front();
					report_field("frame_status", 16'(exp_r.status), 16'(frame_status));
					report_field("left_count", exp_r.left, left_count);
					report_field("right_count", exp_r.right, right_count);
					report_field("steer_position", exp_r.steer, steer_position);
					report_field("left_fresh", 16'(exp_r.left_new), 16'(left_fresh));
					report_field("right_fresh", 16'(exp_r.right_new), 16'(right_fresh));
					report_field("position_fresh", 16'(exp_r.steer_new),
						16'(position_fresh));
				end
			end
			if (in_valid && !in_stall)
				take_byte(rx_byte);
			outstanding = reports_due.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import tfr_pkg::*;

	localparam int FRAME_LENGTH = 11;
	localparam int ITEMS_PER_PHASE = 425;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         frame_status;
	logic signed [15:0] left_count;
	logic signed [15:0] right_count;
	logic signed [15:0] steer_position;
	logic               left_fresh;
	logic               right_fresh;
	logic               position_fresh;
	int                 failures;
	int                 outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	int sent_count = 0;

	logic [7:0] opening [24] = '{
		8'h00, 8'hFF,
		8'hD8, 8'hB0, 8'h80, 8'h00, 8'hB1, 8'h7F, 8'hFF, 8'hB2, 8'hFF, 8'hFF, 8'hEE,
		8'hD8, 8'hB0, 8'h00, 8'h00, 8'hB1, 8'h00, 8'h01, 8'hB2, 8'h12, 8'h34, 8'h00
	};

	tagged_frame_receiver #(.FRAME_LENGTH(FRAME_LENGTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_status(frame_status), .left_count(left_count),
		.right_count(right_count), .steer_position(steer_position),
		.left_fresh(left_fresh), .right_fresh(right_fresh),
		.position_fresh(position_fresh)
	);

	frame_checker #(.FRAME_LENGTH(FRAME_LENGTH)) watch (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_status(frame_status), .left_count(left_count),
		.right_count(right_count), .steer_position(steer_position),
		.left_fresh(left_fresh), .right_fresh(right_fresh),
		.position_fresh(position_fresh),
		.failures(failures), .outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] pick_word;
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] pick_tag(input logic [7:0] tag);
		return ($urandom_range(0, 99) < 80) ? tag : 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame;
		logic [7:0]  frame [FRAME_LENGTH];
		logic [15:0] w;
		int          len;
		frame[0] = HEADER_BYTE;
		frame[1] = pick_tag(TAG_LEFT);
		w = pick_word();
		frame[2] = w[15:8];
		frame[3] = w[7:0];
		frame[4] = pick_tag(TAG_RIGHT);
		w = pick_word();
		frame[5] = w[15:8];
		frame[6] = w[7:0];
		frame[7] = pick_tag(TAG_POSITION);
		w = pick_word();
		frame[8] = w[15:8];
		frame[9] = w[7:0];
		frame[10] = ($urandom_range(0, 99) < 85) ? TAIL_BYTE : 8'($urandom_range(0, 255));
		len = ($urandom_range(0, 99) < 8) ? $urandom_range(1, FRAME_LENGTH - 1) : FRAME_LENGTH;
		for (int i = 0; i < len; i++)
			send_byte(frame[i]);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_byte(opening[i]);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 53; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 53; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			while (sent_count < 24 + (phase + 1) * ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 10)
					send_byte(8'($urandom_range(0, 255)));
				else
					send_frame();
				if ($urandom_range(0, 99) < 2)
					drain();
			end
			drain();
		end

		stall_pct = 0;
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("tagged_frame_receiver regression: pass");
		else
			$display("tagged_frame_receiver regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tagged_frame_receiver regression: fail");
		$finish;
	end

endmodule
